[src/hvps_pkg.sv]
// Shared constants and types of the high-voltage precharge sequencer.
`default_nettype none

package hvps_pkg;

	// Width of the delay countdown.
	localparam int unsigned DELAY_BITS = 16;
	// Width of each delay register and of the configuration data.
	localparam int unsigned CFG_DATA_W = 16;
	// Width of the configuration register index.
	localparam int unsigned CFG_INDEX_W = 3;
	// Width of the reported phase code.
	localparam int unsigned PHASE_W = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_GROUND    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARGE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRECHARGE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE   = 3'd4;

	typedef logic [CFG_DATA_W-1:0] delay_t;

	// The five delay registers as the sequencing logic sees them.
	typedef struct packed {
		delay_t ground;
		delay_t charge;
		delay_t precharge;
		delay_t settle;
		delay_t release_d;
	} delays_t;

	// One result word.
	typedef struct packed {
		logic               ground_relay;
		logic               charge_relay;
		logic               bridge_relay;
		logic               contactor_relay;
		logic               fatal_fault;
		logic               sequence_done;
		logic [PHASE_W-1:0] phase;
	} result_t;

endpackage

`default_nettype wire

[src/hvps_core.sv]
// Sequencer state and the next-state logic for one timer tick.
`default_nettype none

module hvps_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             loop_open,
	input  wire logic             comparator_high,
	input  wire hvps_pkg::delays_t delays,
	output hvps_pkg::result_t     result
);
	import hvps_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		P_IDLE      = 4'd0,
		P_GROUND    = 4'd1,
		P_CHARGE    = 4'd2,
		P_PRECHARGE = 4'd3,
		P_COMPARE   = 4'd4,
		P_SETTLE    = 4'd5,
		P_RELEASE   = 4'd6,
		P_DONE      = 4'd7,
		P_FATAL     = 4'd8
	} phase_t;

	typedef struct packed {
		logic ground;
		logic charge;
		logic precharge;
		logic contactor;
	} relays_t;

	typedef struct packed {
		phase_t                phase;
		logic [DELAY_BITS-1:0] count;
		relays_t               relays;
		logic                  past_comp;
		logic                  done;
		logic                  fatal;
	} state_t;

	state_t                cur_q;
	state_t                nxt;
	logic                  count_zero;
	logic [DELAY_BITS-1:0] count_dec;

	assign count_zero = (cur_q.count == '0);
	assign count_dec  = cur_q.count - DELAY_BITS'(1);

	always_comb begin
		nxt = cur_q;
		if (cur_q.fatal) begin
			nxt.relays = '0;
			nxt.phase  = P_FATAL;
		end else if (loop_open) begin
			// Loop open drops every relay; a high comparator after the check is fatal.
			nxt.relays = '0;
			if (comparator_high && cur_q.past_comp) begin
				nxt.fatal = 1'b1;
				nxt.phase = P_FATAL;
			end else begin
				nxt.phase     = P_IDLE;
				nxt.count     = '0;
				nxt.past_comp = 1'b0;
				nxt.done      = 1'b0;
			end
		end else begin
			unique case (cur_q.phase)
				P_GROUND: begin
					if (count_zero) begin
						nxt.relays.ground = 1'b1;
						nxt.phase         = P_CHARGE;
						nxt.count         = DELAY_BITS'(delays.charge);
					end else begin
						nxt.count = count_dec;
					end
				end
				P_CHARGE: begin
					if (count_zero) begin
						nxt.relays.charge = 1'b1;
						nxt.phase         = P_PRECHARGE;
						nxt.count         = DELAY_BITS'(delays.precharge);
					end else begin
						nxt.count = count_dec;
					end
				end
				P_PRECHARGE: begin
					if (count_zero) begin
						nxt.relays.precharge = 1'b1;
						nxt.phase            = P_COMPARE;
					end else begin
						nxt.count = count_dec;
					end
				end
				P_COMPARE: begin
					if (!comparator_high) begin
						nxt.past_comp = 1'b1;
						nxt.phase     = P_SETTLE;
						nxt.count     = DELAY_BITS'(delays.settle);
					end
				end
				P_SETTLE: begin
					if (count_zero) begin
						nxt.relays.contactor = 1'b1;
						nxt.phase            = P_RELEASE;
						nxt.count            = DELAY_BITS'(delays.release_d);
					end else begin
						nxt.count = count_dec;
					end
				end
				P_RELEASE: begin
					if (count_zero) begin
						nxt.relays.ground    = 1'b0;
						nxt.relays.precharge = 1'b0;
						nxt.done             = 1'b1;
						nxt.phase            = P_DONE;
					end else begin
						nxt.count = count_dec;
					end
				end
				P_DONE: begin
					nxt.phase = P_DONE;
				end
				default: begin
					// Idle, and any code without a meaning, starts the sequence unless it is already done.
					if (!cur_q.done) begin
						nxt.phase = P_GROUND;
						nxt.count = DELAY_BITS'(delays.ground);
					end else begin
						nxt.phase = P_DONE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{phase: P_IDLE, count: '0, relays: '0,
			           past_comp: 1'b0, done: 1'b0, fatal: 1'b0};
		end else if (step) begin
			cur_q <= nxt;
		end
	end

	assign result.ground_relay    = nxt.relays.ground;
	assign result.charge_relay    = nxt.relays.charge;
	assign result.bridge_relay    = nxt.relays.precharge;
	assign result.contactor_relay = nxt.relays.contactor;
	assign result.fatal_fault     = nxt.fatal;
	assign result.sequence_done   = nxt.done;
	assign result.phase           = PHASE_W'(nxt.phase);

endmodule

`default_nettype wire

[src/hv_precharge_sequencer.sv]
// Top level of the high-voltage precharge relay sequencer.
`default_nettype none

// Channel   Signals                                  Direction  Word
// in        in_valid/in_ready, loop_open,            input      one timer tick
//           comparator_high
// out       out_valid/out_ready, relay drives,       output     state after the tick
//           fatal_fault, sequence_done, phase
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data input      one delay register
//
// One tick word is accepted every cycle while the downstream keeps up. A word is held
// in the input register and its result word is then presented from the result
// register. The sequencer state updates at the edge where the word leaves the input
// register. Reset clears the sequencer to idle with all relays open and loads the
// default delays. A stalled result register holds its word and the input register
// keeps accepting only while it has a free slot.

module hv_precharge_sequencer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output      logic                             in_ready,
	input  wire logic                             loop_open,
	input  wire logic                             comparator_high,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic                             ground_relay,
	output      logic                             charge_relay,
	output      logic                             bridge_relay,
	output      logic                             contactor_relay,
	output      logic                             fatal_fault,
	output      logic                             sequence_done,
	output      logic [hvps_pkg::PHASE_W-1:0]     phase,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [hvps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [hvps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hvps_pkg::*;

	// Default delays after reset.
	localparam delay_t RST_GROUND    = 16'd1;
	localparam delay_t RST_CHARGE    = 16'd1;
	localparam delay_t RST_PRECHARGE = 16'd5;
	localparam delay_t RST_SETTLE    = 16'd5;
	localparam delay_t RST_RELEASE   = 16'd5;

	delays_t delays_q;
	logic    valid_s1;
	logic    loop_open_s1;
	logic    comp_s1;
	logic    advance;
	result_t result;
	result_t out_q;
	logic    out_valid_q;

	// Configuration writes are always taken; unknown indexes fall through.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q <= '{ground: RST_GROUND, charge: RST_CHARGE, precharge: RST_PRECHARGE,
			              settle: RST_SETTLE, release_d: RST_RELEASE};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GROUND:    delays_q.ground    <= cfg_data;
				REG_CHARGE:    delays_q.charge    <= cfg_data;
				REG_PRECHARGE: delays_q.precharge <= cfg_data;
				REG_SETTLE:    delays_q.settle    <= cfg_data;
				REG_RELEASE:   delays_q.release_d <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The tick in the input register is processed when the result register
	// is empty or is being emptied in this same cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			loop_open_s1 <= loop_open;
			comp_s1      <= comparator_high;
		end
	end

	hvps_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.loop_open       (loop_open_s1),
		.comparator_high (comp_s1),
		.delays          (delays_q),
		.result          (result)
	);

	// Result register: filled by the tick being processed, emptied by out_ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign ground_relay    = out_q.ground_relay;
	assign charge_relay    = out_q.charge_relay;
	assign bridge_relay    = out_q.bridge_relay;
	assign contactor_relay = out_q.contactor_relay;
	assign fatal_fault     = out_q.fatal_fault;
	assign sequence_done   = out_q.sequence_done;
	assign phase           = out_q.phase;

endmodule

`default_nettype wire

[tb/hv_precharge_sequencer_tb.sv]
// Self-checking testbench for the high-voltage precharge relay sequencer.
`timescale 1ns / 100ps

module hv_precharge_sequencer_tb;
	import hvps_pkg::*;

	// Sequencer phases as the block reports them.
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE      = 4'd0,
		PH_GROUND    = 4'd1,
		PH_CHARGE    = 4'd2,
		PH_PRECHARGE = 4'd3,
		PH_WAIT_COMP = 4'd4,
		PH_SETTLE    = 4'd5,
		PH_RELEASE   = 4'd6,
		PH_DONE      = 4'd7,
		PH_FATAL     = 4'd8
	} seq_phase_t;

	// Number of decoded delay registers; anything from here upwards is ignored.
	localparam int     REG_COUNT     = 5;

	localparam delay_t DELAY_MAX     = 16'hFFFF;
	localparam delay_t LONG_SETTLE   = 16'd32;
	localparam int     RANDOM_TICKS  = 900;
	// Idling is switched off for the tail of the random part and everything after it.
	localparam int     QUIET_FROM    = 780;
	localparam int     HOLD_CYCLES   = 64;
	// Two pipeline registers, with some margin.
	localparam int     DRAIN_CYCLES  = 4;
	localparam int     TIMEOUT_NS    = 20_000_000;

	// Relay drives held by the predictor.
	typedef struct packed {
		logic ground;
		logic charge;
		logic precharge;
		logic contactor;
	} relays_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   loop_open;
	logic                   comparator_high;
	logic                   out_valid;
	logic                   out_ready;
	logic                   ground_relay;
	logic                   charge_relay;
	logic                   bridge_relay;
	logic                   contactor_relay;
	logic                   fatal_fault;
	logic                   sequence_done;
	logic [PHASE_W-1:0]     phase;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predicted sequencer state and the delays it believes are programmed.
	delays_t               delay_cfg;
	seq_phase_t            seq_phase;
	logic [DELAY_BITS-1:0] seq_count;
	relays_t               seq_relays;
	logic                  seq_past_comp;
	logic                  seq_done;
	logic                  seq_fatal;

	// Relay states still to come out of the block, oldest first.
	result_t expected_states[$];

	bit in_gaps_on    = 1'b1;
	bit out_stalls_on = 1'b1;
	bit hold_request  = 1'b0;
	int dwell_left    = 3;

	int ticks_sent      = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int holds_done      = 0;
	int error_count     = 0;

	hv_precharge_sequencer u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The whole run is bounded; a hung handshake ends up here.
	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A delay phase first counts its loaded value down to zero; the tick that
	// finds the count already at zero is the one that acts.
	function automatic bit count_expired();
		if (seq_count == '0)
			return 1'b1;
		seq_count = seq_count - 1'b1;
		return 1'b0;
	endfunction

	// Advances the predicted state by one tick and returns the relay state
	// that the block must report for it.
	function automatic result_t step_sequencer(logic lo, logic ch);
		result_t r;
		if (seq_fatal) begin
			// Once latched, nothing but reset gets the block out of here.
			seq_relays = '0;
			seq_phase  = PH_FATAL;
		end else if (lo) begin
			// An open loop drops every relay. If the comparator has already
			// been seen low and is now high, the bus is in trouble: latch fatal.
			seq_relays = '0;
			if (ch && seq_past_comp) begin
				seq_fatal = 1'b1;
				seq_phase = PH_FATAL;
			end else begin
				seq_phase     = PH_IDLE;
				seq_count     = '0;
				seq_past_comp = 1'b0;
				seq_done      = 1'b0;
			end
		end else begin
			case (seq_phase)
				PH_GROUND: begin
					if (count_expired()) begin
						seq_relays.ground = 1'b1;
						seq_phase         = PH_CHARGE;
						seq_count         = delay_cfg.charge;
					end
				end
				PH_CHARGE: begin
					if (count_expired()) begin
						seq_relays.charge = 1'b1;
						seq_phase         = PH_PRECHARGE;
						seq_count         = delay_cfg.precharge;
					end
				end
				PH_PRECHARGE: begin
					if (count_expired()) begin
						seq_relays.precharge = 1'b1;
						seq_phase            = PH_WAIT_COMP;
					end
				end
				PH_WAIT_COMP: begin
					if (!ch) begin
						seq_past_comp = 1'b1;
						seq_phase     = PH_SETTLE;
						seq_count     = delay_cfg.settle;
					end
				end
				PH_SETTLE: begin
					if (count_expired()) begin
						seq_relays.contactor = 1'b1;
						seq_phase            = PH_RELEASE;
						seq_count            = delay_cfg.release_d;
					end
				end
				PH_RELEASE: begin
					if (count_expired()) begin
						seq_relays.ground    = 1'b0;
						seq_relays.precharge = 1'b0;
						seq_done             = 1'b1;
						seq_phase            = PH_DONE;
					end
				end
				PH_DONE: begin
				end
				default: begin
					// Idle: a closed loop starts the sequence; the starting tick
					// itself does not count towards the ground delay.
					if (!seq_done) begin
						seq_phase = PH_GROUND;
						seq_count = delay_cfg.ground;
					end else begin
						seq_phase = PH_DONE;
					end
				end
			endcase
		end
		r.ground_relay    = seq_relays.ground;
		r.charge_relay    = seq_relays.charge;
		r.bridge_relay    = seq_relays.precharge;
		r.contactor_relay = seq_relays.contactor;
		r.fatal_fault     = seq_fatal;
		r.sequence_done   = seq_done;
		r.phase           = seq_phase;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void check_field(string name, logic [3:0] want_v, logic [3:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			error_count++;
		end
	endfunction

	// Every word that leaves the block is held against the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_states.size() == 0) begin
				$error("result word arrived with no tick waiting for it");
				error_count++;
			end else begin
				want = expected_states.pop_front();
				results_checked++;
				check_field("ground_relay", 4'(want.ground_relay), 4'(ground_relay));
				check_field("charge_relay", 4'(want.charge_relay), 4'(charge_relay));
				check_field("bridge_relay", 4'(want.bridge_relay), 4'(bridge_relay));
				check_field("contactor_relay", 4'(want.contactor_relay),
				            4'(contactor_relay));
				check_field("fatal_fault", 4'(want.fatal_fault), 4'(fatal_fault));
				check_field("sequence_done", 4'(want.sequence_done), 4'(sequence_done));
				check_field("phase", want.phase, phase);
			end
		end
	end

	// ------------------------------------------------------------------
	// Downstream side
	// ------------------------------------------------------------------

	// Output ready: random stall bursts of random length, and on request one long
	// hold so that the pipeline fills and pushes back on the input.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready    <= 1'b0;
				hold_request  = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready  <= 1'b0;
				stall_left  = $urandom_range(0, 4);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Upstream side
	// ------------------------------------------------------------------

	// Offers one tick word, possibly after a short idle burst, and predicts
	// its result once the block has taken it.
	task automatic send_tick(input logic lo, input logic ch);
		int gap;
		if (in_gaps_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		loop_open       <= lo;
		comparator_high <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_states.push_back(step_sequencer(lo, ch));
		ticks_sent++;
	endtask

	// Stops offering words and lets every outstanding result come out.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_states.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Delay registers are only written with the block drained; keeping it idle is up to the caller.
	task automatic write_delay(input logic [CFG_INDEX_W-1:0] idx, input delay_t data);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_GROUND:    delay_cfg.ground    = data;
			REG_CHARGE:    delay_cfg.charge    = data;
			REG_PRECHARGE: delay_cfg.precharge = data;
			REG_SETTLE:    delay_cfg.settle    = data;
			REG_RELEASE:   delay_cfg.release_d = data;
			default: begin
			end
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_delays(input delay_t data);
		for (int i = 0; i < REG_COUNT; i++)
			write_delay(CFG_INDEX_W'(i), data);
	endtask

	// Holds the loop closed until the predicted phase reaches the target. In
	// the comparator wait the comparator stays high for comp_ticks ticks and
	// then falls; elsewhere its level is irrelevant and is left random.
	task automatic run_closed_until(input seq_phase_t target, input int comp_ticks);
		int   held;
		logic ch;
		held = 0;
		while (seq_phase != target) begin
			if (seq_phase == PH_WAIT_COMP) begin
				ch = (held < comp_ticks);
				held++;
			end else begin
				ch = 1'($urandom_range(0, 1));
			end
			send_tick(1'b0, ch);
		end
	endtask

	// One tick of a mostly well-formed session: the loop stays closed, the
	// comparator tends to linger high in the comparator wait, the loop opens
	// after a random dwell in the done phase, and now and then it opens at
	// random to break the sequence.
	task automatic send_session_tick();
		logic lo;
		logic ch;
		lo = ($urandom_range(0, 39) == 0);
		if (seq_phase == PH_DONE) begin
			if (dwell_left == 0)
				lo = 1'b1;
			else
				dwell_left--;
		end
		if (seq_phase == PH_WAIT_COMP)
			ch = ($urandom_range(0, 2) != 0);
		else
			ch = 1'($urandom_range(0, 1));
		// The fatal latch is permanent, so it is kept for the closing test.
		if (lo && seq_past_comp)
			ch = 1'b0;
		send_tick(lo, ch);
		if (lo)
			dwell_left = $urandom_range(0, 8);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset delays: walk to the comparator wait, then open the loop with the
	// comparator high. The comparator has not yet been seen low, so the block
	// must go back to idle rather than fatal.
	task automatic test_reset_delays();
		run_closed_until(PH_WAIT_COMP, 0);
		send_tick(1'b1, 1'b1);
	endtask

	// All delays zero: the shortest full sequence, a short stay in the done
	// phase, then the loop opens with the comparator low.
	task automatic test_zero_delays();
		write_all_delays('0);
		run_closed_until(PH_DONE, 1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
	endtask

	// Writes to undecoded indexes must leave the delays alone, which the
	// zero-delay timing of the following ticks shows.
	task automatic test_ignored_index();
		for (int i = REG_COUNT; i < 2**CFG_INDEX_W; i++)
			write_delay(CFG_INDEX_W'(i), delay_t'($urandom_range(0, 65535)));
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
	endtask

	// Largest delays loaded everywhere: the count runs down a few ticks and
	// the loop opens long before it could expire.
	task automatic test_max_delays();
		write_all_delays(DELAY_MAX);
		repeat (4) send_tick(1'b0, 1'($urandom_range(0, 1)));
		send_tick(1'b1, 1'($urandom_range(0, 1)));
	endtask

	// Long downstream hold while ticks keep coming: the block has to fill up
	// and drop its input ready without losing or duplicating a word.
	task automatic test_output_hold();
		write_all_delays(16'd2);
		hold_request = 1'b1;
		repeat (60) send_session_tick();
	endtask

	// Random sessions under changing delay settings.
	task automatic test_random_sessions();
		int start;
		start = ticks_sent;
		while (ticks_sent - start < RANDOM_TICKS) begin
			if (ticks_sent - start >= QUIET_FROM) begin
				in_gaps_on    = 1'b0;
				out_stalls_on = 1'b0;
			end
			// New settings only between sessions, with the block idle. Mostly
			// short delays so that sessions complete, now and then longer.
			if (seq_phase == PH_IDLE && $urandom_range(0, 7) == 0) begin
				for (int i = 0; i < REG_COUNT; i++) begin
					if ($urandom_range(0, 2) != 0) begin
						case ($urandom_range(0, 9))
							0:       write_delay(CFG_INDEX_W'(i), '0);
							1:       write_delay(CFG_INDEX_W'(i),
							                     delay_t'($urandom_range(5, 40)));
							default: write_delay(CFG_INDEX_W'(i),
							                     delay_t'($urandom_range(0, 4)));
						endcase
					end
				end
			end
			send_session_tick();
		end
	endtask

	// A long settle delay counts all the way down, with the other delays at
	// zero, and the sequence still completes.
	task automatic test_longest_settle();
		write_all_delays('0);
		write_delay(REG_SETTLE, LONG_SETTLE);
		run_closed_until(PH_DONE, 2);
		send_tick(1'b1, 1'b0);
	endtask

	// Runs last, since only reset clears it: from the done phase the loop
	// opens with the comparator high, which latches the fatal state. Every
	// later tick, whatever it carries, must leave all relays open.
	task automatic test_fatal_latch();
		write_all_delays('0);
		run_closed_until(PH_DONE, 1);
		send_tick(1'b1, 1'b1);
		repeat (20) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------

	initial begin
		in_valid        = 1'b0;
		loop_open       = 1'b0;
		comparator_high = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		arst_n          = 1'b0;

		// The predictor starts from the reset state of the block.
		delay_cfg     = '{ground: 16'd1, charge: 16'd1, precharge: 16'd5,
		                   settle: 16'd5, release_d: 16'd5};
		seq_phase     = PH_IDLE;
		seq_count     = '0;
		seq_relays    = '0;
		seq_past_comp = 1'b0;
		seq_done      = 1'b0;
		seq_fatal     = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_delays();
		test_zero_delays();
		test_ignored_index();
		test_max_delays();
		test_output_hold();
		test_random_sessions();
		test_longest_settle();
		test_fatal_latch();

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Run covered %0d ticks, %0d register writes and %0d long output hold(s);",
		         ticks_sent, reg_writes, holds_done);
		$display("%0d result words checked, fatal latch reached: %0d, mismatches: %0d.",
		         results_checked, seq_fatal, error_count);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
